FILE: src/gfge_pkg.sv
// Shared types and constants for the grid flow graph edit engine.
package gfge_pkg;

    localparam int MAX_ROWS = 64;
    localparam int MAX_COLS = 64;

    localparam logic [1:0] OP_WRITE  = 2'd0;
    localparam logic [1:0] OP_READ   = 2'd1;
    localparam logic [1:0] OP_CHANGE = 2'd2;
    localparam logic [1:0] OP_CYCLE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BOUNDS = 2'd1;
    localparam logic [1:0] ST_REJECT = 2'd2;
    localparam logic [1:0] ST_CYCLE  = 2'd3;

    localparam logic [1:0] CFG_ROWS = 2'd0;
    localparam logic [1:0] CFG_COLS = 2'd1;
    localparam logic [1:0] CFG_WRAP = 2'd2;

    localparam logic [7:0] ROOT_DIR = 8'd255;
    localparam logic [2:0] DIR_NE = 3'd1;
    localparam logic [2:0] DIR_SE = 3'd3;
    localparam logic [2:0] DIR_SW = 3'd5;
    localparam logic [2:0] DIR_NW = 3'd7;

    typedef struct packed {
        logic [7:0]  vis;
        logic [7:0]  edges;
        logic [11:0] down;
        logic [7:0]  dir;
    } vertex_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DIV,
        S_RD_V,
        S_WT_V,
        S_RD_OLD,
        S_WT_OLD,
        S_NEIGH,
        S_MUL_NEW,
        S_RD_NEW,
        S_WT_NEW,
        S_CHK,
        S_MUL_X,
        S_RD_X,
        S_WT_X,
        S_WR_V,
        S_WR_OLD,
        S_WR_NEW,
        S_CY_RD,
        S_CY_WT,
        S_DONE
    } state_t;

endpackage

FILE: src/gfge_divider.sv
// Restoring divider: splits a vertex index into row and column.
module gfge_divider
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [11:0] dividend,
    input  logic [10:0] divisor,
    output logic        busy,
    output logic [11:0] quotient,
    output logic [11:0] remainder
);
    logic [11:0] quo_reg;
    logic [11:0] rem_reg;
    logic [3:0]  cnt_reg;
    logic        busy_reg;
    logic [12:0] trial;

    assign trial = {rem_reg, quo_reg[11]} - {2'd0, divisor};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 4'd11;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 4'd0)
                busy_reg <= 1'b0;
            cnt_reg <= cnt_reg - 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (!trial[12])
            begin
                rem_reg <= trial[11:0];
                quo_reg <= {quo_reg[10:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[10:0], quo_reg[11]};
                quo_reg <= {quo_reg[10:0], 1'b0};
            end
        end
    end

    assign busy      = busy_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg) else $error("divider restarted while busy");
    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        start |=> busy_reg) else $error("divider did not start");
    a_rem_lt: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy_reg) |-> (rem_reg < {1'b0, divisor}))
        else $error("remainder not below divisor");
`endif
endmodule

FILE: src/grid_flow_graph_edit_engine_top.sv
// Grid flow graph edit engine: one-item sequencer around a vertex memory.
// Reroute splits the vertex index into row and column with the divider, and the
// cycle check walks downstream vertices; one item in flight at a time.
// The output register frees the sequencer once a result is latched.
// rst_n is asynchronous: clears control, config to 64 x 64 without wrap.
// Vertex memory has no reset; unwritten entries read undefined.
module grid_flow_graph_edit_engine_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // opcode[1:0] vertex_index[13:2] new_direction[16:14] walk_mark[24:17]
    // write_direction[32:25] write_down_index[44:33] write_edges[52:45]
    // write_visited[60:53]
    input  logic [63:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // status[1:0] read_direction[9:2] read_down_index[21:10]
    // read_edges[29:22] read_visited[37:30]
    output logic [39:0] m_axis_tdata,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [6:0]  cfg_data
);
    import gfge_pkg::*;

    localparam int DEPTH = MAX_ROWS * MAX_COLS;
    localparam int AW    = $clog2(DEPTH);

    logic [6:0] rows_cfg_reg, cols_cfg_reg;
    logic       wrap_reg;
    logic [10:0] rows_eff, cols_eff;
    logic [21:0] total;

    always_comb
    begin
        rows_eff = (rows_cfg_reg == 7'd0) ? 11'd1 :
                   ({4'd0, rows_cfg_reg} > 11'(MAX_ROWS)) ? 11'(MAX_ROWS) :
                   {4'd0, rows_cfg_reg};
        cols_eff = (cols_cfg_reg == 7'd0) ? 11'd1 :
                   ({4'd0, cols_cfg_reg} > 11'(MAX_COLS)) ? 11'(MAX_COLS) :
                   {4'd0, cols_cfg_reg};
        total = {11'd0, rows_eff} * {11'd0, cols_eff};
    end

    assign cfg_ready = 1'b1;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_cfg_reg <= 7'd64;
            cols_cfg_reg <= 7'd64;
            wrap_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_ROWS: rows_cfg_reg <= cfg_data;
                CFG_COLS: cols_cfg_reg <= cfg_data;
                CFG_WRAP: wrap_reg     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // memory
    vertex_t mem [DEPTH];
    logic          mem_we;
    logic [AW-1:0] mem_addr;
    vertex_t       mem_wd, mem_rd_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_addr] <= mem_wd;
        mem_rd_reg <= mem[mem_addr];
    end

    // cycle walk: vertex data arrives in the cycle after the read in S_CY_WT
    vertex_t cy_v;
    assign cy_v = mem_rd_reg;

    // item registers
    state_t state_reg, state_next;
    logic [1:0]  op_reg;
    logic [11:0] a_reg;
    logic [2:0]  dnew_reg;
    logic [7:0]  chk_reg;
    vertex_t     wv_reg;
    vertex_t     v_reg, vold_reg, vnew_reg;
    logic [11:0] aold_reg, anew_reg, ax_reg;
    logic [11:0] r_reg, c_reg;
    logic [11:0] nc_reg;
    logic [21:0] prod_reg;
    logic [1:0]  st_reg;
    logic        out_valid_reg;
    logic [39:0] out_data_reg;

    logic        div_start, div_busy;
    logic [11:0] div_q, div_r;

    gfge_divider u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start),
        .dividend(a_reg), .divisor(cols_eff), .busy(div_busy),
        .quotient(div_q), .remainder(div_r)
    );

    logic accept;
    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;

    // neighbor row/col (signed 13 bit)
    logic signed [12:0] dr, dc, nr_c, nc_c, xr_c;
    logic        in_bounds_a, nb_ok, x_ok;
    logic [7:0]  mask_v;
    logic        reject;

    always_comb
    begin
        case (dnew_reg)
            3'd0: begin dr = -13'sd1; dc = 13'sd0;  end
            3'd1: begin dr = -13'sd1; dc = 13'sd1;  end
            3'd2: begin dr = 13'sd0;  dc = 13'sd1;  end
            3'd3: begin dr = 13'sd1;  dc = 13'sd1;  end
            3'd4: begin dr = 13'sd1;  dc = 13'sd0;  end
            3'd5: begin dr = 13'sd1;  dc = -13'sd1; end
            3'd6: begin dr = 13'sd0;  dc = -13'sd1; end
            default: begin dr = -13'sd1; dc = -13'sd1; end
        endcase
        nr_c = $signed({1'b0, r_reg}) + dr;
        nc_c = $signed({1'b0, c_reg}) + dc;
        if (wrap_reg)
        begin
            if (nr_c == -13'sd1) nr_c = nr_c + $signed({2'b0, rows_eff});
            else if (nr_c == $signed({2'b0, rows_eff}))
                nr_c = nr_c - $signed({2'b0, rows_eff});
            if (nc_c == -13'sd1) nc_c = nc_c + $signed({2'b0, cols_eff});
            else if (nc_c == $signed({2'b0, cols_eff}))
                nc_c = nc_c - $signed({2'b0, cols_eff});
        end
        nb_ok = !nr_c[12] && (nr_c < $signed({2'b0, rows_eff}))
             && !nc_c[12] && (nc_c < $signed({2'b0, cols_eff}));
        xr_c = $signed({1'b0, r_reg});
        if (dnew_reg == DIR_NE || dnew_reg == DIR_NW)
            xr_c = xr_c - 13'sd1;
        else if (dnew_reg == DIR_SE || dnew_reg == DIR_SW)
            xr_c = xr_c + 13'sd1;
        x_ok = !xr_c[12] && (xr_c < $signed({2'b0, rows_eff}));
        in_bounds_a = {10'd0, a_reg} < total;
        mask_v = 8'd1 << dnew_reg;
        if (v_reg.dir < 8'd8)
            mask_v = mask_v | (8'd1 << v_reg.dir[2:0]);
        reject = (v_reg.dir == ROOT_DIR) || ({5'd0, dnew_reg} == v_reg.dir)
              || v_reg.edges[dnew_reg];
    end

    always_comb
    begin
        state_next = state_reg;
        mem_we = 1'b0;
        mem_addr = a_reg[AW-1:0];
        mem_wd = wv_reg;
        div_start = 1'b0;
        case (state_reg)
            S_IDLE:    if (accept) state_next = S_RD_V;
            S_RD_V:
            begin
                if (!in_bounds_a) state_next = S_DONE;
                else if (op_reg == OP_WRITE)
                begin
                    mem_we = 1'b1;
                    state_next = S_DONE;
                end
                else state_next = S_WT_V;
            end
            S_WT_V:
            begin
                if (op_reg == OP_CHANGE) state_next = S_RD_OLD;
                else if (op_reg == OP_CYCLE) state_next = S_CY_WT;
                else state_next = S_DONE;
            end
            S_RD_OLD:
            begin
                mem_addr = v_reg.down[AW-1:0];
                if ({10'd0, v_reg.down} >= total) state_next = S_DONE;
                else
                begin
                    div_start = 1'b1;
                    state_next = S_WT_OLD;
                end
            end
            S_WT_OLD:  state_next = S_DIV;
            S_DIV:     if (!div_busy) state_next = S_NEIGH;
            S_NEIGH:   state_next = nb_ok ? S_MUL_NEW : S_DONE;
            S_MUL_NEW: state_next = S_RD_NEW;
            S_RD_NEW:
            begin
                mem_addr = anew_reg[AW-1:0];
                state_next = S_WT_NEW;
            end
            S_WT_NEW:  state_next = S_CHK;
            S_CHK:     state_next = (reject || !x_ok) ? S_DONE : S_MUL_X;
            S_MUL_X:   state_next = S_RD_X;
            S_RD_X:
            begin
                mem_addr = ax_reg[AW-1:0];
                state_next = S_WT_X;
            end
            S_WT_X:
            begin
                // keep the crossing vertex on the read port for S_WR_V
                mem_addr = ax_reg[AW-1:0];
                state_next = S_WR_V;
            end
            S_WR_V:
            begin
                if (!((dnew_reg == DIR_NE && mem_rd_reg.edges[DIR_SE]) ||
                      (dnew_reg == DIR_NW && mem_rd_reg.edges[DIR_SW]) ||
                      (dnew_reg == DIR_SE && mem_rd_reg.edges[DIR_NE]) ||
                      (dnew_reg == DIR_SW && mem_rd_reg.edges[DIR_NW])))
                begin
                    mem_we = 1'b1;
                    mem_wd = '{vis: v_reg.vis, edges: v_reg.edges ^ mask_v,
                               down: anew_reg, dir: {5'd0, dnew_reg}};
                    state_next = S_WR_OLD;
                end
                else state_next = S_DONE;
            end
            S_WR_OLD:
            begin
                mem_we = 1'b1;
                mem_addr = aold_reg[AW-1:0];
                mem_wd = vold_reg;
                mem_wd.edges = vold_reg.edges ^ (8'd1 << (v_reg.dir[2:0] + 3'd4));
                state_next = S_WR_NEW;
            end
            S_WR_NEW:
            begin
                mem_we = 1'b1;
                mem_addr = anew_reg[AW-1:0];
                mem_wd = vnew_reg;
                mem_wd.edges = vnew_reg.edges ^ (8'd1 << (dnew_reg + 3'd4));
                state_next = S_DONE;
            end
            S_CY_RD:
            begin
                if (cy_v.dir == ROOT_DIR || cy_v.vis == chk_reg || cy_v.vis != 8'd0)
                    state_next = S_DONE;
                else
                begin
                    mem_we = 1'b1;
                    mem_wd = cy_v;
                    mem_wd.vis = cy_v.vis + chk_reg;
                    state_next = S_CY_WT;
                end
            end
            S_CY_WT:
            begin
                // issue read of next vertex (address set in a_reg)
                mem_addr = a_reg[AW-1:0];
                state_next = in_bounds_a ? S_CY_RD : S_DONE;
            end
            S_DONE:    if (!out_valid_reg || m_axis_tready) state_next = S_IDLE;
            default:   state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_DONE && (!out_valid_reg || m_axis_tready))
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= s_axis_tdata[1:0];
            a_reg    <= s_axis_tdata[13:2];
            dnew_reg <= s_axis_tdata[16:14];
            chk_reg  <= s_axis_tdata[24:17];
            wv_reg   <= '{vis: s_axis_tdata[60:53], edges: s_axis_tdata[52:45],
                          down: s_axis_tdata[44:33], dir: s_axis_tdata[32:25]};
            st_reg   <= ST_OK;
            v_reg    <= '0;
        end
        case (state_reg)
            S_RD_V:   if (!in_bounds_a) st_reg <= ST_BOUNDS;
            S_WT_V:   v_reg <= mem_rd_reg;
            S_RD_OLD:
            begin
                aold_reg <= v_reg.down;
                if ({10'd0, v_reg.down} >= total) st_reg <= ST_BOUNDS;
            end
            S_WT_OLD: vold_reg <= mem_rd_reg;
            S_DIV:
            begin
                r_reg <= div_q;
                c_reg <= div_r;
            end
            S_NEIGH:
            begin
                nc_reg <= nc_c[11:0];
                if (!nb_ok) st_reg <= ST_BOUNDS;
                prod_reg <= {10'd0, nr_c[11:0]} * {11'd0, cols_eff};
            end
            S_MUL_NEW: anew_reg <= prod_reg[11:0] + nc_reg;
            S_WT_NEW: vnew_reg <= mem_rd_reg;
            S_CHK:
            begin
                if (reject) st_reg <= ST_REJECT;
                else if (!x_ok) st_reg <= ST_BOUNDS;
                prod_reg <= {10'd0, xr_c[11:0]} * {11'd0, cols_eff};
            end
            S_MUL_X:  ax_reg <= prod_reg[11:0] + c_reg;
            S_WR_V:   if (state_next == S_DONE) st_reg <= ST_REJECT;
            S_CY_WT:  if (!in_bounds_a) st_reg <= ST_BOUNDS;
            S_CY_RD:
            begin
                if (cy_v.dir != ROOT_DIR && cy_v.vis == chk_reg)
                    st_reg <= ST_CYCLE;
                else if (state_next == S_CY_WT)
                    a_reg <= cy_v.down;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                    out_data_reg <= {2'b0,
                                     (op_reg == OP_READ && st_reg == ST_OK) ?
                                     {v_reg.vis, v_reg.edges, v_reg.down, v_reg.dir} :
                                     36'd0,
                                     st_reg};
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef ASSERT_OFF
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !s_axis_tready) else $error("second item taken while busy");
    a_hold_out: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("result dropped");
    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE) |-> !mem_we) else $error("memory write while idle");
`endif
endmodule

FILE: tb/sv/tb_grid_flow_graph_edit_engine_top.sv
// Self-checking testbench for the grid flow graph edit engine: directed and random ops.
`timescale 1ns / 100ps

module tb_grid_flow_graph_edit_engine_top;
    import gfge_pkg::*;

    localparam int IDLE_LIMIT = 60000;
    localparam int MEM_SIZE   = 4096;
    localparam int ROW_STEP [8] = '{-1, -1, 0, 1, 1, 1, 0, -1};
    localparam int COL_STEP [8] = '{0, 1, 1, 1, 0, -1, -1, -1};

    typedef struct {
        logic [1:0]  op;
        logic [11:0] idx;
        logic [2:0]  new_dir;
        logic [7:0]  chk;
        vertex_t     wv;
    } job_t;

    typedef struct {
        logic [1:0] st;
        vertex_t    rv;
    } outcome_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [63:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [39:0] m_axis_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [6:0]  cfg_data;

    grid_flow_graph_edit_engine_top u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    // grid model
    vertex_t    vmem [MEM_SIZE];
    vertex_t    vsave [MEM_SIZE];
    bit         written [MEM_SIZE];
    logic [6:0] rows_reg = 7'd64;
    logic [6:0] cols_reg = 7'd64;
    logic       wrap_reg = 1'b0;
    bit         faulted;
    int         fault_addr;

    outcome_t   pending_q [$];
    int         errors = 0;
    int         n_items = 0;
    int         n_results = 0;
    int         n_cfg = 0;
    int         op_count [4] = '{0, 0, 0, 0};
    int         st_count [4] = '{0, 0, 0, 0};
    bit         calm = 1'b0;
    bit         took = 1'b0;
    int         hold = 0;
    int         idle_cycles = 0;

    initial clk = 1'b0;
    always #1 clk = ~clk;

    function automatic int rows_eff();
        if (rows_reg == 0) return 1;
        return (rows_reg > 64) ? 64 : int'(rows_reg);
    endfunction

    function automatic int cols_eff();
        if (cols_reg == 0) return 1;
        return (cols_reg > 64) ? 64 : int'(cols_reg);
    endfunction

    function automatic int area();
        return rows_eff() * cols_eff();
    endfunction

    function automatic vertex_t peek(int a);
        if (!written[a] && !faulted) begin
            faulted    = 1'b1;
            fault_addr = a;
        end
        return vmem[a];
    endfunction

    function automatic logic [1:0] reroute(int a, int dn);
        int      rows, cols, aold, anew, r, c, nr, nc, dold;
        vertex_t v, vo, vn, vx;
        logic [7:0] mask;
        rows = rows_eff();
        cols = cols_eff();
        if (a >= area()) return ST_BOUNDS;
        v    = peek(a);
        dold = v.dir;
        aold = v.down;
        if (aold >= area()) return ST_BOUNDS;
        vo = peek(aold);
        r  = a / cols;
        c  = a % cols;
        nr = r + ROW_STEP[dn];
        nc = c + COL_STEP[dn];
        if (wrap_reg) begin
            if (nr == -1) nr += rows;
            else if (nr == rows) nr -= rows;
            if (nc == -1) nc += cols;
            else if (nc == cols) nc -= cols;
        end
        if (nr < 0 || nr >= rows || nc < 0 || nc >= cols) return ST_BOUNDS;
        anew = nr * cols + nc;
        vn   = peek(anew);
        if (dold == ROOT_DIR || dn == dold || v.edges[dn]) return ST_REJECT;
        nr = r;
        if (dn == DIR_NE || dn == DIR_NW) nr = r - 1;
        else if (dn == DIR_SE || dn == DIR_SW) nr = r + 1;
        if (nr < 0 || nr >= rows) return ST_BOUNDS;
        vx = peek(nr * cols + c);
        if (dn == DIR_NE && vx.edges[DIR_SE]) return ST_REJECT;
        if (dn == DIR_NW && vx.edges[DIR_SW]) return ST_REJECT;
        if (dn == DIR_SE && vx.edges[DIR_NE]) return ST_REJECT;
        if (dn == DIR_SW && vx.edges[DIR_NW]) return ST_REJECT;
        mask = 8'd1 << dn;
        if (dold < 8) mask |= 8'd1 << dold;
        v.down  = anew[11:0];
        v.dir   = dn[7:0];
        v.edges = v.edges ^ mask;
        vmem[a] = v;
        vo.edges   = vo.edges ^ (8'd1 << ((dold + 4) % 8));
        vmem[aold] = vo;
        vn.edges   = vn.edges ^ (8'd1 << ((dn + 4) % 8));
        vmem[anew] = vn;
        return ST_OK;
    endfunction

    function automatic logic [1:0] cycle_walk(int a, logic [7:0] chk);
        vertex_t v;
        if (a >= area()) return ST_BOUNDS;
        v = peek(a);
        while (v.dir != ROOT_DIR && !faulted) begin
            if (v.vis == chk) return ST_CYCLE;
            if (v.vis != 0) return ST_OK;
            v.vis   = v.vis + chk;
            vmem[a] = v;
            a       = v.down;
            if (a >= area()) return ST_BOUNDS;
            v = peek(a);
        end
        return ST_OK;
    endfunction

    // returns 0 when the job would touch a never-written vertex; state is then left as it was
    function automatic bit predict_grid_op(job_t j, output outcome_t res);
        faulted = 1'b0;
        vsave   = vmem;
        res.st  = ST_OK;
        res.rv  = '0;
        case (j.op)
            OP_WRITE: begin
                if (j.idx >= area()) res.st = ST_BOUNDS;
                else begin
                    vmem[j.idx]    = j.wv;
                    written[j.idx] = 1'b1;
                end
            end
            OP_READ: begin
                if (j.idx >= area()) res.st = ST_BOUNDS;
                else res.rv = peek(j.idx);
            end
            OP_CHANGE: res.st = reroute(j.idx, j.new_dir);
            default:   res.st = cycle_walk(j.idx, j.chk);
        endcase
        if (faulted) vmem = vsave;
        return !faulted;
    endfunction

    function automatic vertex_t random_vertex();
        vertex_t v;
        int      pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) v.dir = 8'($urandom_range(0, 7));
        else if (pick < 85) v.dir = ROOT_DIR;
        else v.dir = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 99) < 85) v.down = 12'($urandom_range(0, area() - 1));
        else v.down = 12'($urandom_range(0, 4095));
        v.edges = 8'($urandom_range(0, 255));
        v.vis   = ($urandom_range(0, 99) < 75) ? 8'd0 : 8'($urandom_range(0, 255));
        return v;
    endfunction

    function automatic job_t random_job();
        job_t j;
        int   pick;
        pick = $urandom_range(0, 99);
        if (pick < 35) j.op = OP_WRITE;
        else if (pick < 55) j.op = OP_READ;
        else if (pick < 85) j.op = OP_CHANGE;
        else j.op = OP_CYCLE;
        if ($urandom_range(0, 99) < 90) j.idx = 12'($urandom_range(0, area() - 1));
        else j.idx = 12'($urandom_range(0, 4095));
        j.new_dir = 3'($urandom_range(0, 7));
        j.chk     = ($urandom_range(0, 9) == 0) ? 8'd0 : 8'($urandom_range(1, 255));
        j.wv      = random_vertex();
        return j;
    endfunction

    task automatic send_grid_op(job_t j);
        outcome_t res;
        int       gap;
        if (!predict_grid_op(j, res)) begin
            j.op  = OP_WRITE;
            j.idx = 12'(fault_addr);
            j.wv  = random_vertex();
            void'(predict_grid_op(j, res));
        end
        pending_q.push_back(res);
        op_count[j.op]++;
        n_items++;
        gap = calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b0, j.wv.vis, j.wv.edges, j.wv.down, j.wv.dir,
                          j.chk, j.new_dir, j.idx, j.op};
        do @(posedge clk); while (!s_axis_tready);
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_q.size() != 0) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_cfg(logic [1:0] idx, logic [6:0] val);
        wait_drained();
        repeat (40) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_ROWS: rows_reg = val;
            CFG_COLS: cols_reg = val;
            default:  wrap_reg = val[0];
        endcase
        n_cfg++;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_grid(logic [6:0] r, logic [6:0] c, logic w);
        write_cfg(CFG_ROWS, r);
        write_cfg(CFG_COLS, c);
        write_cfg(CFG_WRAP, {6'b0, w});
    endtask

    function automatic job_t make_job(logic [1:0] op, int idx, int nd, int chk);
        job_t j;
        j.op      = op;
        j.idx     = 12'(idx);
        j.new_dir = 3'(nd);
        j.chk     = 8'(chk);
        j.wv      = '0;
        return j;
    endfunction

    // 3x3 grid: roots on the right column but for vertex 8, odd stored direction, bad downstream index
    task automatic test_directed();
        job_t j;
        set_grid(7'd3, 7'd3, 1'b0);
        calm = 1'b1;
        for (int i = 0; i < 9; i++) begin
            j          = make_job(OP_WRITE, i, 0, 0);
            j.wv.dir   = (i % 3 == 2) ? ROOT_DIR : 8'd2;
            j.wv.down  = 12'(i + 1);
            j.wv.edges = 8'h04;
            if (i == 0) j.wv = '{vis: 8'hFF, edges: 8'hFF, down: 12'd4, dir: 8'd200};
            if (i == 8) j.wv = '{vis: 8'h00, edges: 8'h00, down: 12'hFFF, dir: 8'd0};
            send_grid_op(j);
        end
        calm = 1'b0;
        send_grid_op(make_job(OP_READ, 0, 0, 0));
        send_grid_op(make_job(OP_READ, 4095, 0, 0));
        j = make_job(OP_WRITE, 4095, 0, 0);
        j.wv = '{vis: 8'hFF, edges: 8'hFF, down: 12'hFFF, dir: ROOT_DIR};
        send_grid_op(j);
        send_grid_op(make_job(OP_CHANGE, 2, 4, 0));
        send_grid_op(make_job(OP_CHANGE, 1, 2, 0));
        send_grid_op(make_job(OP_CHANGE, 1, 4, 0));
        send_grid_op(make_job(OP_CHANGE, 3, 7, 0));
        send_grid_op(make_job(OP_CHANGE, 4, 1, 0));
        send_grid_op(make_job(OP_CHANGE, 0, 3, 0));
        send_grid_op(make_job(OP_CHANGE, 8, 0, 0));
        send_grid_op(make_job(OP_CYCLE, 0, 0, 0));
        send_grid_op(make_job(OP_CYCLE, 3, 0, 5));
        send_grid_op(make_job(OP_CYCLE, 3, 0, 5));
        send_grid_op(make_job(OP_CYCLE, 4, 0, 200));
    endtask

    task automatic test_random_phase(logic [6:0] r, logic [6:0] c, logic w, int n);
        set_grid(r, c, w);
        for (int i = 0; i < n; i++) begin
            calm = (i < n / 4);
            if (i == n / 2) wait_drained();
            send_grid_op(random_job());
        end
        calm = 1'b0;
    endtask

    always @(posedge clk) begin
        outcome_t exp_res;
        logic [1:0] st;
        vertex_t    got;
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || (cfg_valid && cfg_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("%0t watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("status: fail");
            $finish;
        end
        if (rst_n && m_axis_tvalid && m_axis_tready) begin
            took = 1'b1;
            st   = m_axis_tdata[1:0];
            got  = '{vis: m_axis_tdata[37:30], edges: m_axis_tdata[29:22],
                     down: m_axis_tdata[21:10], dir: m_axis_tdata[9:2]};
            n_results++;
            if (pending_q.size() == 0) begin
                errors++;
                $display("%0t unexpected result: status %0d", $time, st);
            end else begin
                exp_res = pending_q.pop_front();
                st_count[exp_res.st]++;
                if (st !== exp_res.st) begin
                    errors++;
                    $display("%0t status: exp %0d got %0d", $time, exp_res.st, st);
                end
                if (got.dir !== exp_res.rv.dir) begin
                    errors++;
                    $display("%0t read_direction: exp %0d got %0d", $time,
                             exp_res.rv.dir, got.dir);
                end
                if (got.down !== exp_res.rv.down) begin
                    errors++;
                    $display("%0t read_down_index: exp %0d got %0d", $time,
                             exp_res.rv.down, got.down);
                end
                if (got.edges !== exp_res.rv.edges) begin
                    errors++;
                    $display("%0t read_edges: exp %h got %h", $time,
                             exp_res.rv.edges, got.edges);
                end
                if (got.vis !== exp_res.rv.vis) begin
                    errors++;
                    $display("%0t read_visited: exp %0d got %0d", $time,
                             exp_res.rv.vis, got.vis);
                end
            end
        end
    end

    always @(negedge clk) begin
        if (took) begin
            took = 1'b0;
            hold = calm ? 0 : $urandom_range(0, 8);
        end
        if (hold > 0) begin
            m_axis_tready <= 1'b0;
            hold--;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        m_axis_tready = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_ROWS;
        cfg_data      = '0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_directed();
        test_random_phase(7'd0, 7'd127, 1'b1, 90);
        test_random_phase(7'd127, 7'd0, 1'b0, 90);
        test_random_phase(7'd1, 7'd1, 1'b1, 60);
        test_random_phase(7'd8, 7'd8, 1'b1, 110);
        test_random_phase(7'd8, 7'd8, 1'b0, 110);
        test_random_phase(7'd5, 7'd7, 1'b1, 110);
        test_random_phase(7'd2, 7'd2, 1'b1, 80);
        test_random_phase(7'd64, 7'd64, 1'b0, 100);
        test_random_phase(7'd64, 7'd64, 1'b1, 100);
        wait_drained();
        repeat (40) @(negedge clk);
        $display("covered %0d items (write %0d read %0d reroute %0d cycle %0d), %0d cfg writes",
                 n_items, op_count[0], op_count[1], op_count[2], op_count[3], n_cfg);
        $display("results %0d: ok %0d bounds %0d rejected %0d cycle %0d, mismatches %0d",
                 n_results, st_count[0], st_count[1], st_count[2], st_count[3], errors);
        if (errors == 0 && pending_q.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
src/gfge_pkg.sv
src/gfge_divider.sv
src/grid_flow_graph_edit_engine_top.sv
tb/sv/tb_grid_flow_graph_edit_engine_top.sv
